@@ src/streaming_sum_of_squared_deviations_unit_defines.svh @@
// Assertion macros shared by the checker of the squared deviation unit.
`ifndef STREAMING_SUM_OF_SQUARED_DEVIATIONS_UNIT_DEFINES_SVH
`define STREAMING_SUM_OF_SQUARED_DEVIATIONS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ssd_pkg.sv @@
// Shared constants and types of the squared deviation unit.
package ssd_pkg;

	// Set size limit and sample width.
	localparam int MAX_ITEMS   = 4096;
	localparam int SAMPLE_BITS = 16;

	// Derived widths.
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_ITEMS);
	localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
	localparam int ACC_W  = SQ_W + $clog2(MAX_ITEMS);
	localparam int DIVD_W = 2 * SUM_W;
	localparam int STEP_W = $clog2(DIVD_W);

	// Queue of finished set totals between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	// Totals of one finished data set.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [ACC_W-1:0]        sq_sum;
		logic [CNT_W-1:0]        count;
		logic                    ovf;
	} set_totals_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              empty;
	} q_status_t;

endpackage

@@ src/ssd_front.sv @@
// Front part: accepts samples, squares them and accumulates per data set.
module ssd_front import ssd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	input  q_status_t                     q_status,
	output logic                          push,
	output set_totals_t                   push_data
);

	logic                          accept;
	logic                          take;
	logic [CNT_W-1:0]              count_q;
	logic                          ovf_q;
	logic [CNT_W-1:0]              cnt_next;
	logic [QLVL_W:0]               reserved;

	logic                          valid_s1, last_s1, take_s1, ovf_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic [CNT_W-1:0]              cnt_s1;
	logic signed [2*SAMPLE_BITS-1:0] prod;

	logic                          valid_s2, last_s2, take_s2, ovf_s2;
	logic signed [SAMPLE_BITS-1:0] x_s2;
	logic [SQ_W-1:0]               sq_s2;
	logic [CNT_W-1:0]              cnt_s2;

	logic signed [SUM_W-1:0]       sum_q, sum_nx;
	logic [ACC_W-1:0]              sq_sum_q, sq_sum_nx;

	// Every set end in flight holds a queue slot, so a push never finds the queue full.
	assign reserved = {1'b0, q_status.level} + (QLVL_W+1)'(valid_s1 & last_s1)
		+ (QLVL_W+1)'(valid_s2 & last_s2);
	assign sample_stall = reserved >= (QLVL_W+1)'(QDEPTH);
	assign accept = sample_valid && !sample_stall;

	// Samples past the limit are dropped and flag the set.
	assign take = count_q < CNT_W'(MAX_ITEMS);
	assign cnt_next = take ? count_q + CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (last_sample) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= cnt_next;
				ovf_q   <= ovf_q | ~take;
			end
		end
	end

	// Stage 1: capture the sample with its count and overflow state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			last_s1  <= last_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= sample;
			take_s1 <= take;
			cnt_s1  <= cnt_next;
			ovf_s1  <= ovf_q | ~take;
		end
	end

	// Stage 2: register the square.
	assign prod = x_s1 * x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			x_s2    <= x_s1;
			sq_s2   <= prod[SQ_W-1:0];
			take_s2 <= take_s1;
			cnt_s2  <= cnt_s1;
			ovf_s2  <= ovf_s1;
		end
	end

	// Accumulate; a set end hands the totals to the queue and clears them.
	assign sum_nx    = take_s2 ? sum_q + SUM_W'(x_s2) : sum_q;
	assign sq_sum_nx = take_s2 ? sq_sum_q + ACC_W'(sq_s2) : sq_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			sq_sum_q <= '0;
		end else if (valid_s2) begin
			if (last_s2) begin
				sum_q    <= '0;
				sq_sum_q <= '0;
			end else begin
				sum_q    <= sum_nx;
				sq_sum_q <= sq_sum_nx;
			end
		end
	end

	assign push             = valid_s2 && last_s2;
	assign push_data.sum    = sum_nx;
	assign push_data.sq_sum = sq_sum_nx;
	assign push_data.count  = cnt_s2;
	assign push_data.ovf    = ovf_s2;

endmodule

@@ src/ssd_queue.sv @@
// Short queue of finished set totals between the front and the back.
module ssd_queue import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  set_totals_t push_data,
	input  logic        pop,
	output set_totals_t rd_data,
	output q_status_t   q_status
);

	set_totals_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QLVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QLVL_W'(1);
			end
		end
	end

	assign rd_data        = mem_q[rd_ptr_q];
	assign q_status.level = level_q;
	assign q_status.empty = level_q == '0;

endmodule

@@ src/ssd_back.sv @@
// Back part: squares the set sum, divides by the count and forms the result.
module ssd_back import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  q_status_t         q_status,
	input  set_totals_t       rd_data,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [ACC_W-1:0]  squared_deviation_sum,
	output logic [CNT_W-1:0]  item_count,
	output logic              overflowed
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SQUARE = 2'd1;
	localparam logic [1:0] ST_DIVIDE = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]        state_q;
	logic [SUM_W-1:0]  mag;
	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W-1:0]  n_q;
	logic [ACC_W-1:0]  sq_sum_q;
	logic              ovf_q;
	logic [DIVD_W-1:0] div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    shifted;
	logic              ge;
	logic              load_out;
	logic              result_valid_q;

	// Magnitude of the set sum; the most negative sum maps to its unsigned value.
	assign mag = rd_data.sum[SUM_W-1] ? SUM_W'(~rd_data.sum) + SUM_W'(1) : SUM_W'(rd_data.sum);

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	assign shifted = {rem_q, div_q[DIVD_W-1]};
	assign ge      = shifted >= {1'b0, n_q};

	assign pop      = (state_q == ST_IDLE) && !q_status.empty;
	assign load_out = (state_q == ST_FINISH) && (!result_valid_q || !result_stall);

	// Sequencer for one set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					step_q  <= '0;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIVD_W - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath of the division; the quotient shifts in behind the dividend.
	always_ff @(posedge clk) begin
		if (pop) begin
			mag_q    <= mag;
			n_q      <= rd_data.count;
			sq_sum_q <= rd_data.sq_sum;
			ovf_q    <= rd_data.ovf;
		end
		if (state_q == ST_SQUARE) begin
			div_q <= mag_q * mag_q;
			rem_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			rem_q <= ge ? CNT_W'(shifted - {1'b0, n_q}) : shifted[CNT_W-1:0];
			div_q <= {div_q[DIVD_W-2:0], ge};
		end
	end

	// Output register; the quotient never exceeds the sum of squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			squared_deviation_sum <= sq_sum_q - div_q[ACC_W-1:0];
			item_count            <= n_q;
			overflowed            <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;

endmodule

@@ src/streaming_sum_of_squared_deviations_unit.sv @@
// Top level of the streaming sum of squared deviations unit.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------------------
//   input    | sample_valid / sample_stall | sample, last_sample
//   output   | result_valid / result_stall | squared_deviation_sum, item_count, overflowed
//
// Samples are taken at one per cycle while sample_stall is low; a set end passes
// front stages 1 and 2 before it is pushed into the queue. The back divides at one
// quotient bit per cycle, and up to four finished sets wait in the queue.
// sample_stall rises only while every queue slot is filled or spoken for.
// arst_n clears all control state and the accumulators at once; no clearing pass.
module streaming_sum_of_squared_deviations_unit import ssd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ACC_W-1:0]              squared_deviation_sum,
	output logic [CNT_W-1:0]              item_count,
	output logic                          overflowed
);

	logic        push;
	logic        pop;
	set_totals_t push_data;
	set_totals_t rd_data;
	q_status_t   q_status;

	// Accumulation of incoming samples.
	ssd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.last_sample  (last_sample),
		.q_status     (q_status),
		.push         (push),
		.push_data    (push_data)
	);

	// Finished set totals waiting for the divider.
	ssd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.rd_data   (rd_data),
		.q_status  (q_status)
	);

	// Division and result output.
	ssd_back u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.q_status              (q_status),
		.rd_data               (rd_data),
		.pop                   (pop),
		.result_valid          (result_valid),
		.result_stall          (result_stall),
		.squared_deviation_sum (squared_deviation_sum),
		.item_count            (item_count),
		.overflowed            (overflowed)
	);

endmodule

@@ src/ssd_checker.sv @@
// Port-level checker of the squared deviation unit and its bind.
`include "streaming_sum_of_squared_deviations_unit_defines.svh"

module ssd_checker import ssd_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_stall,
	input logic signed [SAMPLE_BITS-1:0] sample,
	input logic                          last_sample,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [ACC_W-1:0]              squared_deviation_sum,
	input logic [CNT_W-1:0]              item_count,
	input logic                          overflowed
);

	// A stalled result stays offered and unchanged.
	`SSD_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid, "result dropped while stalled")
	`SSD_ASSERT_NEXT(a_out_stable, result_valid && result_stall, $stable(squared_deviation_sum) && $stable(item_count) && $stable(overflowed), "stalled result changed")

	// A result covers at least one and at most the limit of samples.
	`SSD_ASSERT_SAME(a_count_range, result_valid, item_count != '0 && item_count <= CNT_W'(MAX_ITEMS), "item count out of range")

	// Dropped samples happen only once the set is full.
	`SSD_ASSERT_SAME(a_ovf_full, result_valid && overflowed, item_count == CNT_W'(MAX_ITEMS), "overflow with a set that is not full")

endmodule

bind streaming_sum_of_squared_deviations_unit ssd_checker u_ssd_checker (.*);

@@ test/ssd_deviation_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts and compares the results of the squared deviation unit.
module ssd_deviation_checker import ssd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [ACC_W-1:0]              squared_deviation_sum,
	input  logic [CNT_W-1:0]              item_count,
	input  logic                          overflowed,
	output int                            mismatch_count,
	output int                            pending_results
);

	// One finished data set as the block should report it.
	typedef struct packed {
		logic [ACC_W-1:0] deviation;
		logic [CNT_W-1:0] count;
		logic             overflow;
	} set_deviation_t;

	set_deviation_t awaited_deviations[$];

	// Running totals of the data set that is streaming in.
	logic signed [SUM_W-1:0] set_sum;
	logic [ACC_W-1:0]        set_square_sum;
	logic [CNT_W-1:0]        set_count;
	logic                    set_overflow;

	initial begin
		mismatch_count = 0;
		pending_results = 0;
	end

	// Sum of squares minus floor(sum squared / count), clamped at zero.
	function automatic logic [ACC_W-1:0] squared_deviation(
		input logic signed [SUM_W-1:0] sum,
		input logic [ACC_W-1:0]        square_sum,
		input logic [CNT_W-1:0]        count
	);
		longint          wide_sum;
		longint unsigned magnitude, quotient;
		wide_sum = sum;
		magnitude = (wide_sum < 0) ? -wide_sum : wide_sum;
		quotient = (count == 0) ? 0 : (magnitude * magnitude) / count;
		if (square_sum >= quotient) begin
			return ACC_W'(square_sum - quotient);
		end
		return '0;
	endfunction

	task automatic clear_set_totals();
		set_sum = '0;
		set_square_sum = '0;
		set_count = '0;
		set_overflow = 1'b0;
	endtask

	task automatic report_mismatch(input string field, input longint unsigned got,
		input longint unsigned want);
		$display("[%0t] result field %s: got %0d, want %0d", $time, field, got, want);
		mismatch_count++;
	endtask

	// Predict on every accepted sample, compare on every accepted result.
	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		set_deviation_t want;
		longint         square;
		if (!arst_n) begin
			clear_set_totals();
			awaited_deviations.delete();
			pending_results <= 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				if (set_count < MAX_ITEMS) begin
					square = longint'(sample) * longint'(sample);
					set_sum = set_sum + sample;
					set_square_sum = set_square_sum + square[ACC_W-1:0];
					set_count = set_count + 1'b1;
				end else begin
					set_overflow = 1'b1;
				end
				if (last_sample) begin
					want.deviation = squared_deviation(set_sum, set_square_sum, set_count);
					want.count = set_count;
					want.overflow = set_overflow;
					awaited_deviations.push_back(want);
					clear_set_totals();
				end
			end
			if (result_valid && !result_stall) begin
				if (awaited_deviations.size() == 0) begin
					report_mismatch("item_count of an unexpected transaction", item_count, 0);
				end else begin
					want = awaited_deviations.pop_front();
					if (squared_deviation_sum !== want.deviation) begin
						report_mismatch("squared_deviation_sum", squared_deviation_sum,
							want.deviation);
					end
					if (item_count !== want.count) begin
						report_mismatch("item_count", item_count, want.count);
					end
					if (overflowed !== want.overflow) begin
						report_mismatch("overflowed", overflowed, want.overflow);
					end
				end
			end
			pending_results <= awaited_deviations.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: stimulus, idling and verdict for the squared deviation unit.
module tb;
	import ssd_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 400;
	localparam int SAMPLE_LOW   = -(1 << (SAMPLE_BITS - 1));
	localparam int SAMPLE_HIGH  = (1 << (SAMPLE_BITS - 1)) - 1;

	typedef enum int {
		STYLE_FULL,
		STYLE_TINY,
		STYLE_EXTREME,
		STYLE_CLUSTER,
		STYLE_CONSTANT
	} sample_style_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_stall;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          last_sample = 1'b0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [ACC_W-1:0]              squared_deviation_sum;
	logic [CNT_W-1:0]              item_count;
	logic                          overflowed;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int cycle_count = 0;
	int mismatch_count;
	int pending_results;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	streaming_sum_of_squared_deviations_unit i_dut (.*);

	ssd_deviation_checker i_checker (.*);

	// Hard stop in case the block hangs or results go missing.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	initial begin : receiver
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sample_style_t style,
		input int base);
		case (style)
			STYLE_FULL: return SAMPLE_BITS'($urandom);
			STYLE_TINY: return SAMPLE_BITS'($urandom_range(64) - 32);
			STYLE_EXTREME: begin
				case ($urandom_range(2))
					0: return SAMPLE_BITS'(SAMPLE_LOW);
					1: return SAMPLE_BITS'(SAMPLE_HIGH);
					default: return SAMPLE_BITS'(SAMPLE_LOW + 1);
				endcase
			end
			STYLE_CLUSTER: return SAMPLE_BITS'(base + int'($urandom_range(15)));
			default: return SAMPLE_BITS'(base);
		endcase
	endfunction

	// Offer one sample after a random gap and hold it until it is taken.
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic is_last);
		while ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		last_sample <= is_last;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic send_set(input int len, input sample_style_t style, input int base);
		for (int k = 0; k < len; k++) begin
			send_sample(pick_sample(style, base), k == len - 1);
		end
	endtask

	// Mostly short sets, some medium and a few long ones, with varied value shapes.
	task automatic run_random_phase(input int target_items);
		int            sent;
		int            len;
		int            pick;
		sample_style_t style;
		sent = 0;
		while (sent < target_items) begin
			case ($urandom_range(19))
				0: len = $urandom_range(200, 41);
				1, 2, 3, 4, 5: len = $urandom_range(40, 9);
				default: len = $urandom_range(8, 1);
			endcase
			pick = $urandom_range(7);
			style = (pick > STYLE_CONSTANT) ? STYLE_FULL : sample_style_t'(pick);
			send_set(len, style, int'($urandom_range(SAMPLE_HIGH - SAMPLE_LOW - 15)) + SAMPLE_LOW);
			sent += len;
		end
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-sample sets at the extremes and zero.
		send_set(1, STYLE_CONSTANT, SAMPLE_LOW);
		send_set(1, STYLE_CONSTANT, SAMPLE_HIGH);
		send_set(1, STYLE_CONSTANT, 0);
		// Widest possible spread, then identical extremes.
		send_sample(SAMPLE_BITS'(SAMPLE_LOW), 1'b0);
		send_sample(SAMPLE_BITS'(SAMPLE_HIGH), 1'b1);
		send_set(2, STYLE_CONSTANT, SAMPLE_LOW);
		send_set(3, STYLE_CONSTANT, SAMPLE_HIGH);
		// Sum not divisible by the count, so the quotient is rounded down.
		send_sample(SAMPLE_BITS'(1), 1'b0);
		send_sample(SAMPLE_BITS'(0), 1'b0);
		send_sample(SAMPLE_BITS'(0), 1'b1);
		send_set(6, STYLE_EXTREME, 0);
		send_set(4, STYLE_FULL, 0);

		// Sender mostly busy, receiver mostly stalled.
		idle_pct = 15;
		stall_pct <= 65;
		run_random_phase(PHASE_ITEMS);
		wait_drained();

		// Sender mostly idle, receiver mostly ready.
		idle_pct = 65;
		stall_pct <= 15;
		run_random_phase(PHASE_ITEMS);

		// No idling; a long receiver hold-off while short sets pile up behind it.
		idle_pct = 0;
		stall_pct <= 0;
		hold_requests <= hold_requests + 1;
		for (int k = 0; k < 24; k++) begin
			send_set(1, STYLE_FULL, 0);
		end
		run_random_phase(PHASE_ITEMS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ streaming_sum_of_squared_deviations_unit.f @@
+incdir+src
src/ssd_pkg.sv
src/ssd_front.sv
src/ssd_queue.sv
src/ssd_back.sv
src/streaming_sum_of_squared_deviations_unit.sv
src/ssd_checker.sv
test/ssd_deviation_checker.sv
test/tb.sv
